>>> hdl/smrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package smrs_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int CAPACITY = 256;

  // positions and row starts; wide enough for the largest capacity
  localparam int PTR_W  = 17;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int VAL_W  = 32;
  localparam int CFG_W  = 7;
  localparam int CIDX_W = 8;
  localparam int STAT_W = 2;
  localparam int HELD_W = 9;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 48;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_ROWS_IN_USE = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_COLS_IN_USE = 8'd1;

  // lookup token walking the row-start chain
  typedef struct packed {
    logic             vld;
    logic [PTR_W-1:0] lo;
    logic [PTR_W-1:0] hi;
  } row_tok_t;

  // search key broadcast to the entry chain
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [PTR_W-1:0] lo;
    logic [PTR_W-1:0] hi;
  } scan_key_t;

  // search token walking the entry chain
  typedef struct packed {
    logic             vld;
    logic             found;
    logic             match;
    logic [PTR_W-1:0] pos;
    logic [VAL_W-1:0] val;
  } scan_tok_t;

  // update command for the entry chain
  typedef struct packed {
    logic             wr_en;
    logic             ins_en;
    logic [PTR_W-1:0] pos;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] val;
  } ent_cmd_t;

endpackage
`default_nettype wire

>>> hdl/sparse_matrix_row_store.sv
`timescale 1ns / 1ps
`default_nettype none
// Sparse integer matrix store, compressed-row form.
// Input channel s_axis_*: one get or set request per transfer.
// Output channel m_axis_*: one result per request (value, status, entries held).
// Config channel cfg_*: index 0 rows_in_use, index 1 cols_in_use; always ready,
//   write only while the block is idle. Other indexes are dropped.
// Each in-range request first walks a chain of MaxRows row-start cells to pick up the
// row bounds, then walks a chain of Capacity entry cells that finds the slot.
// An insert shifts all later entries up by one and bumps every following row start
// in the same cycle.
// An out-of-range request skips both chains and goes straight to the response.
// One request in flight at a time; throughput is set by the two chain walks
// for in-range requests.
// Reset empties the store and sets both registers to 64. Entry cells have no
// reset: cells at or beyond the entry count are never looked at.
// A stalled result sits in the output register; the next request is taken
// meanwhile and its result waits until that register frees up.
module sparse_matrix_row_store #(
  parameter int MaxRows  = smrs_pkg::MAX_ROWS,
  parameter int MaxCols  = smrs_pkg::MAX_COLS,
  parameter int Capacity = smrs_pkg::CAPACITY
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // tdata: action[0], row[6:1], col[12:7], value[44:13]
  input  wire logic [smrs_pkg::IN_W-1:0]   s_axis_tdata_i,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: read_value[31:0], status[33:32], entries_held[42:34]
  output logic [smrs_pkg::OUT_W-1:0]       m_axis_tdata_o,
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [smrs_pkg::CIDX_W-1:0] cfg_index_i,
  input  wire logic [smrs_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int PW = smrs_pkg::PTR_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROWS, ST_ENTS, ST_COMMIT, ST_RESP
  } state_e;

  state_e state_q;

  logic                       act_q;
  logic [smrs_pkg::ROW_W-1:0] row_q;
  logic [smrs_pkg::COL_W-1:0] col_q;
  logic [smrs_pkg::VAL_W-1:0] val_q;
  logic [PW-1:0]              count_q;
  logic [smrs_pkg::CFG_W-1:0] rows_cfg_q, cols_cfg_q;
  logic [PW-1:0]              lo_q, hi_q;
  logic                       row_go_q, ent_go_q;
  logic [smrs_pkg::VAL_W-1:0] rd_q;
  logic [smrs_pkg::STAT_W-1:0] stat_q;
  smrs_pkg::ent_cmd_t         cmd_q, cmd;
  logic [smrs_pkg::OUT_W-1:0] out_q;
  logic                       out_vld_q;

  // input fields
  logic                       in_act;
  logic [smrs_pkg::ROW_W-1:0] in_row;
  logic [smrs_pkg::COL_W-1:0] in_col;
  logic [smrs_pkg::VAL_W-1:0] in_val;
  logic                       in_xfer, out_xfer, out_ok, in_range;

  assign in_act = s_axis_tdata_i[0];
  assign in_row = s_axis_tdata_i[6:1];
  assign in_col = s_axis_tdata_i[12:7];
  assign in_val = s_axis_tdata_i[44:13];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = out_vld_q && m_axis_tready_i;
  assign out_ok   = !out_vld_q || m_axis_tready_i;
  assign cfg_ready_o = 1'b1;

  assign in_range = ({1'b0, in_row} < rows_cfg_q) && (PW'(in_row) < PW'(MaxRows)) &&
                    ({1'b0, in_col} < cols_cfg_q) && (PW'(in_col) < PW'(MaxCols));

  // row-start chain
  smrs_pkg::row_tok_t row_tok [MaxRows+1];
  logic               bump;

  assign row_tok[0] = '{vld: row_go_q, lo: '0, hi: '0};
  assign bump = (state_q == ST_COMMIT) && cmd_q.ins_en;

  for (genvar i = 0; i < MaxRows; i++) begin : g_row
    smrs_row_cell #(.Idx(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (row_tok[i]),
      .row_i  (row_q),
      .bump_i (bump),
      .tok_o  (row_tok[i+1])
    );
  end

  // row bounds, clamped to the entry count
  logic [PW-1:0] hi_raw, hi_cl, lo_cl;
  always_comb begin
    hi_raw = (PW'(row_q) == PW'(MaxRows - 1)) ? count_q : row_tok[MaxRows].hi;
    hi_cl  = (hi_raw > count_q) ? count_q : hi_raw;
    lo_cl  = (row_tok[MaxRows].lo > hi_cl) ? hi_cl : row_tok[MaxRows].lo;
  end

  // entry chain
  smrs_pkg::scan_tok_t        ent_tok [Capacity+1];
  smrs_pkg::scan_key_t        key;
  logic [smrs_pkg::COL_W-1:0] ent_col [Capacity];
  logic [smrs_pkg::VAL_W-1:0] ent_val [Capacity];

  assign ent_tok[0] = '{vld: ent_go_q, found: 1'b0, match: 1'b0, pos: '0, val: '0};
  assign key = '{col: col_q, lo: lo_q, hi: hi_q};
  assign cmd = (state_q == ST_COMMIT) ? cmd_q : '0;

  for (genvar i = 0; i < Capacity; i++) begin : g_ent
    if (i == 0) begin : g_first
      smrs_entry_cell #(.Idx(i)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .tok_i      (ent_tok[i]),
        .key_i      (key),
        .cmd_i      (cmd),
        .prev_col_i (cmd.col),
        .prev_val_i (cmd.val),
        .tok_o      (ent_tok[i+1]),
        .col_o      (ent_col[i]),
        .val_o      (ent_val[i])
      );
    end else begin : g_rest
      smrs_entry_cell #(.Idx(i)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .tok_i      (ent_tok[i]),
        .key_i      (key),
        .cmd_i      (cmd),
        .prev_col_i (ent_col[i-1]),
        .prev_val_i (ent_val[i-1]),
        .tok_o      (ent_tok[i+1]),
        .col_o      (ent_col[i]),
        .val_o      (ent_val[i])
      );
    end
  end

  // token leaving the chain unfound means the slot is the row end
  smrs_pkg::scan_tok_t res;
  logic [PW-1:0]       slot;
  logic                hit_match;
  logic                upd_ok, ins_ok;

  assign res       = ent_tok[Capacity];
  assign slot      = res.found ? res.pos : hi_q;
  assign hit_match = res.found && res.match;
  // set on a stored column overwrites; otherwise it inserts if there is room
  assign upd_ok    = (act_q == smrs_pkg::ACT_SET) && hit_match;
  assign ins_ok    = (act_q == smrs_pkg::ACT_SET) && !hit_match &&
                     (count_q < PW'(Capacity));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      rows_cfg_q <= smrs_pkg::CFG_W'(64);
      cols_cfg_q <= smrs_pkg::CFG_W'(64);
      row_go_q   <= 1'b0;
      ent_go_q   <= 1'b0;
      cmd_q      <= '0;
      out_vld_q  <= 1'b0;
      act_q      <= 1'b0;
      row_q      <= '0;
      col_q      <= '0;
      val_q      <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      rd_q       <= '0;
      stat_q     <= smrs_pkg::STAT_OK;
      out_q      <= '0;
    end else begin
      row_go_q <= 1'b0;
      ent_go_q <= 1'b0;
      if (out_xfer) out_vld_q <= 1'b0;

      if (cfg_valid_i) begin
        if (cfg_index_i == smrs_pkg::CFG_ROWS_IN_USE) rows_cfg_q <= cfg_data_i;
        else if (cfg_index_i == smrs_pkg::CFG_COLS_IN_USE) cols_cfg_q <= cfg_data_i;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            act_q <= in_act;
            row_q <= in_row;
            col_q <= in_col;
            val_q <= in_val;
            rd_q  <= '0;
            if (in_range) begin
              stat_q   <= smrs_pkg::STAT_OK;
              row_go_q <= 1'b1;
              state_q  <= ST_ROWS;
            end else begin
              stat_q  <= smrs_pkg::STAT_RANGE;
              state_q <= ST_RESP;
            end
          end
        end
        ST_ROWS: begin
          if (row_tok[MaxRows].vld) begin
            lo_q     <= lo_cl;
            hi_q     <= hi_cl;
            ent_go_q <= 1'b1;
            state_q  <= ST_ENTS;
          end
        end
        ST_ENTS: begin
          if (res.vld) begin
            cmd_q <= '{wr_en: upd_ok, ins_en: ins_ok, pos: slot, col: col_q, val: val_q};
            if (act_q == smrs_pkg::ACT_GET) begin
              rd_q <= hit_match ? res.val : '0;
            end else if (!hit_match && !ins_ok) begin
              stat_q <= smrs_pkg::STAT_FULL;
            end
            if (ins_ok) count_q <= count_q + PW'(1);
            state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          cmd_q   <= '0;
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (out_ok) begin
            out_q     <= {5'd0, count_q[smrs_pkg::HELD_W-1:0], stat_q, rd_q};
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata_o  = out_q;
  assign m_axis_tvalid_o = out_vld_q;

endmodule
`default_nettype wire

>>> hdl/smrs_row_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One row start; catches the row bounds as the lookup token passes.
module smrs_row_cell #(
  parameter int Idx = 0
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire smrs_pkg::row_tok_t         tok_i,
  input  wire logic [smrs_pkg::ROW_W-1:0] row_i,
  input  wire logic                       bump_i,
  output smrs_pkg::row_tok_t              tok_o
);

  localparam logic [smrs_pkg::PTR_W-1:0] MyIdx = smrs_pkg::PTR_W'(Idx);

  logic [smrs_pkg::PTR_W-1:0] start_q;
  logic [smrs_pkg::PTR_W-1:0] row_x;
  smrs_pkg::row_tok_t         tok_d, tok_q;

  assign row_x = smrs_pkg::PTR_W'(row_i);

  always_comb begin
    tok_d = tok_i;
    if (MyIdx == row_x) tok_d.lo = start_q;
    if (MyIdx == row_x + smrs_pkg::PTR_W'(1)) tok_d.hi = start_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (bump_i && MyIdx > row_x) start_q <= start_q + smrs_pkg::PTR_W'(1);
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

>>> hdl/smrs_entry_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One stored entry; checks the passing search token, shifts up on insert.
module smrs_entry_cell #(
  parameter int Idx = 0
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire smrs_pkg::scan_tok_t        tok_i,
  input  wire smrs_pkg::scan_key_t        key_i,
  input  wire smrs_pkg::ent_cmd_t         cmd_i,
  input  wire logic [smrs_pkg::COL_W-1:0] prev_col_i,
  input  wire logic [smrs_pkg::VAL_W-1:0] prev_val_i,
  output smrs_pkg::scan_tok_t             tok_o,
  output logic [smrs_pkg::COL_W-1:0]      col_o,
  output logic [smrs_pkg::VAL_W-1:0]      val_o
);

  localparam logic [smrs_pkg::PTR_W-1:0] MyIdx = smrs_pkg::PTR_W'(Idx);

  logic [smrs_pkg::COL_W-1:0] col_q;
  logic [smrs_pkg::VAL_W-1:0] val_q;
  logic                       past_end;
  logic                       hit;
  smrs_pkg::scan_tok_t        tok_d, tok_q;

  // first slot of the row whose column is not below the key, or the row end
  assign past_end = MyIdx >= key_i.hi;
  assign hit = tok_i.vld && !tok_i.found &&
               (past_end || (MyIdx >= key_i.lo && col_q >= key_i.col));

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.found = 1'b1;
      tok_d.pos   = MyIdx;
      tok_d.match = !past_end && (col_q == key_i.col);
      tok_d.val   = val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_en && MyIdx == cmd_i.pos) begin
      col_q <= cmd_i.col;
      val_q <= cmd_i.val;
    end else if (cmd_i.ins_en && MyIdx > cmd_i.pos) begin
      col_q <= prev_col_i;
      val_q <= prev_val_i;
    end else if (cmd_i.wr_en && MyIdx == cmd_i.pos) begin
      val_q <= cmd_i.val;
    end
  end

  assign tok_o = tok_q;
  assign col_o = col_q;
  assign val_o = val_q;

endmodule
`default_nettype wire

>>> hdl/smrs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module smrs_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tvalid_i,
  input wire logic                        s_axis_tready_o,
  input wire logic [smrs_pkg::OUT_W-1:0]  m_axis_tdata_o,
  input wire logic                        m_axis_tvalid_o,
  input wire logic                        m_axis_tready_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // one request in flight
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while busy");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[33:32] <= smrs_pkg::STAT_FULL)
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[33:32] != smrs_pkg::STAT_OK |->
      m_axis_tdata_o[31:0] == 32'd0)
    else $error("error result carries a value");

  a_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[42:34] <= 9'(smrs_pkg::CAPACITY))
    else $error("entry count above capacity");

endmodule

bind sparse_matrix_row_store smrs_checker u_smrs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);
`default_nettype wire
